FILE: hw/rtl/dbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbc_pkg: shared types and constants for the depth box centroid block
// Widths of the accumulators, multiplier and divider, register map, FSM codes.
// ----------------------------------------------------------------------------
package dbc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DEPTH_BITS_DEF = 16;

  // accumulator and arithmetic widths, sized for the widest parameter values
  localparam int CNT_W  = 20;
  localparam int SUMD_W = 36;
  localparam int SUM_W  = 56;
  localparam int DEN_W  = 36;
  localparam int DX_W   = 20;
  localparam int MUL_W  = 21;
  localparam int PROD_W = 2 * MUL_W;
  localparam int OUT_W  = 18;
  localparam int FWD_W  = 16;
  localparam int CONF_W = 8;
  localparam int REG_W  = 16;

  // floor(v/3) == (v * RECIP3) >> RECIP3_SHIFT for every v below 2**16
  localparam logic [MUL_W-1:0] RECIP3       = MUL_W'(43691);
  localparam int               RECIP3_SHIFT = 17;

  // APB register map
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_FOCAL_X  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_CONF = 3'd4;

  localparam logic [REG_W-1:0]  FOCAL_X_RST  = 16'd9600;
  localparam logic [REG_W-1:0]  FOCAL_Y_RST  = 16'd9600;
  localparam logic [REG_W-1:0]  CENTER_X_RST = 16'd16384;
  localparam logic [REG_W-1:0]  CENTER_Y_RST = 16'd12288;
  localparam logic [CONF_W-1:0] MIN_CONF_RST = 8'd77;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOX_COL,
    ST_BOX_ROW,
    ST_BOX_FIN,
    ST_PIX_X,
    ST_PIX_Y,
    ST_PIX_Z,
    ST_DIV_GO,
    ST_DIV_WAIT
  } dbc_state_t;

  // which quotient the shared divider is working on
  typedef enum logic [1:0] {
    DSEL_DEPTH,
    DSEL_DX,
    DSEL_DY
  } dbc_dsel_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dbc_div_stat_t;

endpackage : dbc_pkg
`default_nettype wire

FILE: hw/rtl/depth_box_centroid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// depth_box_centroid: mean 3D point of a detection box from a depth stream
// Keeps the inner-third window of a box, sums depth and depth-weighted
// offsets of the pixels inside it, and back-projects the mean on the last
// pixel through a pinhole model.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                 Payload
// in_*      start & !busy accepts     command, box corners, confidence, pixel
// out_*     out_strobe, one cycle     forward_mm, left_mm, up_mm, valid_res
// APB       psel&penable&pwrite       focal_x/y, center_x/y, min_confidence
//
// Steps: a box start holds busy through BOX_COL, BOX_ROW and BOX_FIN, a pixel
// through PIX_X, PIX_Y and PIX_Z. A last pixel with a valid result adds three
// divisions on the shared divider, and the result strobe rises as busy falls.
// One shared multiplier serves the window bounds, the weighted offsets and
// the divisor products.
// Reset is synchronous, active low, clears sums and window, and loads the configuration registers with their defaults.
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module depth_box_centroid #(
  parameter int COORD_BITS = dbc_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = dbc_pkg::DEPTH_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_command,
  input  wire logic [COORD_BITS-1:0]            in_box_left,
  input  wire logic [COORD_BITS-1:0]            in_box_right,
  input  wire logic [COORD_BITS-1:0]            in_box_top,
  input  wire logic [COORD_BITS-1:0]            in_box_bottom,
  input  wire logic [dbc_pkg::CONF_W-1:0]       in_confidence,
  input  wire logic [COORD_BITS-1:0]            in_pixel_col,
  input  wire logic [COORD_BITS-1:0]            in_pixel_row,
  input  wire logic [DEPTH_BITS-1:0]            in_depth_mm,
  input  wire logic                             in_last_pixel,
  // result channel
  output logic                                  out_strobe,
  output logic        [dbc_pkg::FWD_W-1:0]      out_forward_mm,
  output logic signed [dbc_pkg::OUT_W-1:0]      out_left_mm,
  output logic signed [dbc_pkg::OUT_W-1:0]      out_up_mm,
  output logic                                  out_valid_res,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [dbc_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [dbc_pkg::PDATA_W-1:0]      pwdata,
  output logic      [dbc_pkg::PDATA_W-1:0]      prdata,
  output logic                                  pready
);
  import dbc_pkg::*;

  localparam int HI3_W   = COORD_BITS + 2;
  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;

  // configuration registers
  logic [REG_W-1:0]  focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [CONF_W-1:0] min_conf_r;

  // sequencer
  dbc_state_t state_r, state_nxt;
  dbc_dsel_t  dsel_r;

  // latched transaction
  logic [COORD_BITS-1:0] bl_r, br_r, bt_r, bb_r, col_r, row_r;
  logic [CONF_W-1:0]     conf_r;
  logic [DEPTH_BITS-1:0] d_r;
  logic                  last_r;

  // box window and accumulators
  logic [COORD_BITS-1:0] col_lo_r, row_lo_r;
  logic [HI3_W-1:0]      col_hi3_r, row_hi3_r;
  logic                  accepted_r;
  logic                  hit_r;
  logic [SUMD_W-1:0]     sum_d_r;
  logic signed [SUM_W-1:0] sum_dx_r, sum_dy_r;
  logic [CNT_W-1:0]      hit_count_r;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_c, prod_r;

  // shared divider
  logic                dv_start;
  logic [SUM_W-1:0]    dv_dividend;
  logic [DEN_W-1:0]    dv_divisor;
  dbc_div_stat_t       dv_stat;
  logic [SUM_W-1:0]    dv_quot;

  // output registers
  logic                    out_strobe_r;
  logic [FWD_W-1:0]        out_fwd_r;
  logic signed [OUT_W-1:0] out_left_r, out_up_r;
  logic                    out_valid_r;

  logic [REG_W-1:0]         fx_eff, fy_eff;
  logic signed [DX_W-1:0]   dx, dy;
  logic [HI3_W-1:0]         col3, row3;
  logic                     in_window, hit;
  logic                     cfg_wr;
  logic                     result_ok;

  // Negate the truncated quotient of a signed sum and clamp to the output range.
  function automatic logic signed [OUT_W-1:0] sat_offset(input logic [SUM_W-1:0] mag,
                                                         input logic sum_neg);
    logic signed [OUT_W-1:0] res;
    if (sum_neg) begin
      res = (mag > SUM_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : mag[OUT_W-1:0];
    end else begin
      res = (mag > SUM_W'(OUT_MAX + 1)) ? OUT_W'(OUT_MAX + 1) : -mag[OUT_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [SUM_W-1:0] magnitude(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? -v : v;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= FOCAL_X_RST;
      focal_y_r  <= FOCAL_Y_RST;
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
      min_conf_r <= MIN_CONF_RST;
    end else if (cfg_wr) begin
      unique case (paddr[PADDR_W-1:2])
        REG_FOCAL_X:  focal_x_r  <= pwdata[REG_W-1:0];
        REG_FOCAL_Y:  focal_y_r  <= pwdata[REG_W-1:0];
        REG_CENTER_X: center_x_r <= pwdata[REG_W-1:0];
        REG_CENTER_Y: center_y_r <= pwdata[REG_W-1:0];
        REG_MIN_CONF: min_conf_r <= pwdata[CONF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_FOCAL_X:  prdata = PDATA_W'(focal_x_r);
      REG_FOCAL_Y:  prdata = PDATA_W'(focal_y_r);
      REG_CENTER_X: prdata = PDATA_W'(center_x_r);
      REG_CENTER_Y: prdata = PDATA_W'(center_y_r);
      REG_MIN_CONF: prdata = PDATA_W'(min_conf_r);
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pixel geometry
  // --------------------------------------------------------------------------
  // a zero focal length counts as one
  assign fx_eff = (focal_x_r == '0) ? REG_W'(1) : focal_x_r;
  assign fy_eff = (focal_y_r == '0) ? REG_W'(1) : focal_y_r;

  assign dx = $signed(DX_W'({col_r, 4'b0000})) - $signed(DX_W'(center_x_r));
  assign dy = $signed(DX_W'({row_r, 4'b0000})) - $signed(DX_W'(center_y_r));

  assign col3 = HI3_W'(col_r) + HI3_W'({col_r, 1'b0});
  assign row3 = HI3_W'(row_r) + HI3_W'({row_r, 1'b0});

  assign in_window = (col_r >= col_lo_r) && (col3 < col_hi3_r) &&
                     (row_r >= row_lo_r) && (row3 < row_hi3_r);
  assign hit = accepted_r && (d_r != '0) && (hit_count_r != '1) && in_window;

  assign result_ok = accepted_r && (hit_count_r != '0);

  // --------------------------------------------------------------------------
  // Shared multiplier: operands chosen by the sequencer, product registered
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_BOX_COL: begin
        mul_a = MUL_W'(HI3_W'({bl_r, 1'b0}) + HI3_W'(br_r));
        mul_b = RECIP3;
      end
      ST_BOX_ROW: begin
        mul_a = MUL_W'(HI3_W'({bt_r, 1'b0}) + HI3_W'(bb_r));
        mul_b = RECIP3;
      end
      ST_PIX_X: begin
        mul_a = MUL_W'(d_r);
        mul_b = MUL_W'(dx);
      end
      ST_PIX_Y: begin
        mul_a = MUL_W'(d_r);
        mul_b = MUL_W'(dy);
      end
      ST_DIV_GO, ST_DIV_WAIT: begin
        // divisor of the next offset quotient: focal times count
        mul_a = MUL_W'((dsel_r == DSEL_DEPTH) ? fx_eff : fy_eff);
        mul_b = MUL_W'(hit_count_r);
      end
      default: ;
    endcase
  end

  assign prod_c = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
  end

  // --------------------------------------------------------------------------
  // Shared divider
  // --------------------------------------------------------------------------
  assign dv_start = (state_r == ST_DIV_GO);

  always_comb begin
    dv_dividend = SUM_W'(sum_d_r);
    dv_divisor  = DEN_W'(hit_count_r);
    case (dsel_r)
      DSEL_DX: begin
        dv_dividend = magnitude(sum_dx_r);
        dv_divisor  = prod_r[DEN_W-1:0];
      end
      DSEL_DY: begin
        dv_dividend = magnitude(sum_dy_r);
        dv_divisor  = prod_r[DEN_W-1:0];
      end
      default: ;
    endcase
  end

  dbc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .stat     (dv_stat),
    .quotient (dv_quot)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = in_command ? ST_PIX_X : ST_BOX_COL;
        end
      end
      ST_BOX_COL: state_nxt = ST_BOX_ROW;
      ST_BOX_ROW: state_nxt = ST_BOX_FIN;
      ST_BOX_FIN: state_nxt = ST_IDLE;
      ST_PIX_X:   state_nxt = ST_PIX_Y;
      ST_PIX_Y:   state_nxt = ST_PIX_Z;
      ST_PIX_Z:   state_nxt = (last_r && result_ok) ? ST_DIV_GO : ST_IDLE;
      ST_DIV_GO:  state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (dv_stat.done) begin
          state_nxt = (dsel_r == DSEL_DY) ? ST_IDLE : ST_DIV_GO;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // hold the accepted transaction for the steps that follow
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      bl_r   <= in_box_left;
      br_r   <= in_box_right;
      bt_r   <= in_box_top;
      bb_r   <= in_box_bottom;
      conf_r <= in_confidence;
      col_r  <= in_pixel_col;
      row_r  <= in_pixel_row;
      d_r    <= in_depth_mm;
      last_r <= in_last_pixel;
    end
  end

  // --------------------------------------------------------------------------
  // Window, accumulators and results
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_lo_r     <= '0;
      col_hi3_r    <= '0;
      row_lo_r     <= '0;
      row_hi3_r    <= '0;
      accepted_r   <= 1'b0;
      hit_r        <= 1'b0;
      sum_d_r      <= '0;
      sum_dx_r     <= '0;
      sum_dy_r     <= '0;
      hit_count_r  <= '0;
      dsel_r       <= DSEL_DEPTH;
      out_strobe_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_fwd_r    <= '0;
      out_left_r   <= '0;
      out_up_r     <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        ST_BOX_COL: begin
          col_hi3_r <= HI3_W'({br_r, 1'b0}) + HI3_W'(bl_r);
          row_hi3_r <= HI3_W'({bb_r, 1'b0}) + HI3_W'(bt_r);
        end
        ST_BOX_ROW: begin
          col_lo_r    <= prod_r[RECIP3_SHIFT +: COORD_BITS];
          accepted_r  <= (conf_r >= min_conf_r);
          sum_d_r     <= '0;
          sum_dx_r    <= '0;
          sum_dy_r    <= '0;
          hit_count_r <= '0;
        end
        ST_BOX_FIN: begin
          row_lo_r <= prod_r[RECIP3_SHIFT +: COORD_BITS];
        end
        ST_PIX_X: begin
          hit_r <= hit;
        end
        ST_PIX_Y: begin
          if (hit_r) begin
            sum_d_r     <= sum_d_r + SUMD_W'(d_r);
            sum_dx_r    <= sum_dx_r + SUM_W'(prod_r);
            hit_count_r <= hit_count_r + 1'b1;
          end
        end
        ST_PIX_Z: begin
          if (hit_r) begin
            sum_dy_r <= sum_dy_r + SUM_W'(prod_r);
          end
          dsel_r <= DSEL_DEPTH;
          if (last_r && !result_ok) begin
            // rejected box or empty window: drop the sums, report invalid
            out_strobe_r <= 1'b1;
            out_valid_r  <= 1'b0;
            out_fwd_r    <= '0;
            out_left_r   <= '0;
            out_up_r     <= '0;
            accepted_r   <= 1'b0;
            sum_d_r      <= '0;
            sum_dx_r     <= '0;
            sum_dy_r     <= '0;
            hit_count_r  <= '0;
          end
        end
        ST_DIV_WAIT: begin
          if (dv_stat.done) begin
            case (dsel_r)
              DSEL_DEPTH: begin
                out_fwd_r <= dv_quot[FWD_W-1:0];
                dsel_r    <= DSEL_DX;
              end
              DSEL_DX: begin
                out_left_r <= sat_offset(dv_quot, sum_dx_r[SUM_W-1]);
                dsel_r     <= DSEL_DY;
              end
              default: begin
                out_up_r     <= sat_offset(dv_quot, sum_dy_r[SUM_W-1]);
                out_strobe_r <= 1'b1;
                out_valid_r  <= 1'b1;
                dsel_r       <= DSEL_DEPTH;
                accepted_r   <= 1'b0;
                sum_d_r      <= '0;
                sum_dx_r     <= '0;
                sum_dy_r     <= '0;
                hit_count_r  <= '0;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_forward_mm = out_fwd_r;
  assign out_left_mm    = out_left_r;
  assign out_up_mm      = out_up_r;
  assign out_valid_res  = out_valid_r;

`ifndef ASSERT_OFF
  // an accepted transaction always leaves the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // results never strobe in two consecutive cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two result strobes in consecutive cycles");

  // an invalid result carries zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_valid_res) |->
      (out_forward_mm == '0) && (out_left_mm == '0) && (out_up_mm == '0))
    else $error("invalid result with nonzero fields");

  // the divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    dv_stat.done |-> (state_r == ST_DIV_WAIT))
    else $error("divider finished outside the wait state");

  // the count advances by one or clears, never anything else
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_count_r != $past(hit_count_r)) |->
      ((hit_count_r == $past(hit_count_r) + 1'b1) || (hit_count_r == '0)))
    else $error("hit count jumped");
`endif

endmodule : depth_box_centroid
`default_nettype wire

FILE: hw/rtl/dbc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbc_div: shared unsigned restoring divider
// One quotient bit per cycle; done pulses once the quotient is complete.
// ----------------------------------------------------------------------------
module dbc_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [dbc_pkg::SUM_W-1:0]  dividend,
  input  wire logic [dbc_pkg::DEN_W-1:0]  divisor,
  output dbc_pkg::dbc_div_stat_t          stat,
  output logic      [dbc_pkg::SUM_W-1:0]  quotient
);
  import dbc_pkg::*;

  localparam int CNT_BITS = $clog2(SUM_W + 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [SUM_W-1:0]    quo_r;
  logic [DEN_W-1:0]    rem_r;
  logic [DEN_W-1:0]    div_r;
  logic [DEN_W:0]      trial;

  assign trial = {rem_r, quo_r[SUM_W-1]} - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      // keep the trial difference when it does not borrow
      if (!trial[DEN_W]) begin
        rem_r <= trial[DEN_W-1:0];
      end else begin
        rem_r <= {rem_r[DEN_W-2:0], quo_r[SUM_W-1]};
      end
      quo_r <= {quo_r[SUM_W-2:0], ~trial[DEN_W]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule : dbc_div
`default_nettype wire
